// File: src/zodl_pkg.sv
package zodl_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = 7;
    localparam int TAG_W  = 16;
    localparam int KEY_W  = 32;
    localparam int CMD_W  = 2;
    localparam int CODE_W = 3;
    localparam int ENT_W  = TAG_W + KEY_W;

    localparam logic [SLOT_W-1:0] SLOT_NONE = 7'd64;

    // input commands
    localparam logic [CMD_W-1:0] CMD_REG    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREG  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RENDER = 2'd2;

    // result codes
    localparam logic [CODE_W-1:0] RC_REGISTERED = 3'd0;
    localparam logic [CODE_W-1:0] RC_REG_IGN    = 3'd1;
    localparam logic [CODE_W-1:0] RC_FULL       = 3'd2;
    localparam logic [CODE_W-1:0] RC_MOVED      = 3'd3;
    localparam logic [CODE_W-1:0] RC_RM_LAST    = 3'd4;
    localparam logic [CODE_W-1:0] RC_RM_IGN     = 3'd5;
    localparam logic [CODE_W-1:0] RC_ENTRY      = 3'd6;
    localparam logic [CODE_W-1:0] RC_EMPTY      = 3'd7;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH      = 5'd1;
    localparam logic [OP_W-1:0] OP_REG_IGN    = 5'd2;
    localparam logic [OP_W-1:0] OP_FULL       = 5'd3;
    localparam logic [OP_W-1:0] OP_REG        = 5'd4;
    localparam logic [OP_W-1:0] OP_RM_IGN     = 5'd5;
    localparam logic [OP_W-1:0] OP_RM_LAST    = 5'd6;
    localparam logic [OP_W-1:0] OP_MOVE_RD    = 5'd7;
    localparam logic [OP_W-1:0] OP_MOVE_WR    = 5'd8;
    localparam logic [OP_W-1:0] OP_SORT_BEGIN = 5'd9;
    localparam logic [OP_W-1:0] OP_SORT_RD    = 5'd10;
    localparam logic [OP_W-1:0] OP_SORT_LD    = 5'd11;
    localparam logic [OP_W-1:0] OP_SRCH_RD    = 5'd12;
    localparam logic [OP_W-1:0] OP_SRCH_CMP   = 5'd13;
    localparam logic [OP_W-1:0] OP_SHIFT_INIT = 5'd14;
    localparam logic [OP_W-1:0] OP_SHIFT_RD   = 5'd15;
    localparam logic [OP_W-1:0] OP_SHIFT_WR   = 5'd16;
    localparam logic [OP_W-1:0] OP_INSERT     = 5'd17;
    localparam logic [OP_W-1:0] OP_EMIT_EMPTY = 5'd18;
    localparam logic [OP_W-1:0] OP_EMIT_FIRST = 5'd19;
    localparam logic [OP_W-1:0] OP_EMIT_RD    = 5'd20;
    localparam logic [OP_W-1:0] OP_EMIT_OUT   = 5'd21;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } zodl_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             slot_none;
        logic             full;
        logic             rm_bad;
        logic             rm_last;
        logic             dirty;
        logic             i_done;
        logic             lo_lt_hi;
        logic             o_gt_lo;
        logic             count_zero;
        logic             emit_last;
        logic             out_free;
    } zodl_stat_t;

endpackage

// File: src/zodl_ram.sv
module zodl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/zodl_ctrl.sv
module zodl_ctrl
    import zodl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  zodl_stat_t stat,
    output zodl_ctrl_t ctrl,
    output logic       idle
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_MOVE_WR    = 4'd2;
    localparam logic [3:0] S_SORT_I     = 4'd3;
    localparam logic [3:0] S_SORT_LD    = 4'd4;
    localparam logic [3:0] S_SRCH       = 4'd5;
    localparam logic [3:0] S_SRCH_CMP   = 4'd6;
    localparam logic [3:0] S_SHIFT      = 4'd7;
    localparam logic [3:0] S_SHIFT_WR   = 4'd8;
    localparam logic [3:0] S_EMIT_START = 4'd9;
    localparam logic [3:0] S_EMIT_RD    = 4'd10;
    localparam logic [3:0] S_EMIT_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;

    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.op    = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // hold until the output register can take a result
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                    priority if (stat.cmd == CMD_REG)
                    begin
                        priority if (!stat.slot_none) ctrl.op = OP_REG_IGN;
                        else if (stat.full)           ctrl.op = OP_FULL;
                        else                          ctrl.op = OP_REG;
                    end
                    else if (stat.cmd == CMD_UNREG)
                    begin
                        priority if (stat.rm_bad) ctrl.op = OP_RM_IGN;
                        else if (stat.rm_last)    ctrl.op = OP_RM_LAST;
                        else
                        begin
                            ctrl.op    = OP_MOVE_RD;
                            state_next = S_MOVE_WR;
                        end
                    end
                    else if (stat.cmd == CMD_RENDER)
                    begin
                        if (stat.dirty)
                        begin
                            ctrl.op    = OP_SORT_BEGIN;
                            state_next = S_SORT_I;
                        end
                        else
                        begin
                            state_next = S_EMIT_START;
                        end
                    end
                    else
                    begin
                        ctrl.op = OP_NONE;
                    end
                end
            end
            S_MOVE_WR:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = OP_MOVE_WR;
                    state_next = S_IDLE;
                end
            end
            S_SORT_I:
            begin
                if (stat.i_done)
                begin
                    state_next = S_EMIT_START;
                end
                else
                begin
                    ctrl.op    = OP_SORT_RD;
                    state_next = S_SORT_LD;
                end
            end
            S_SORT_LD:
            begin
                ctrl.op    = OP_SORT_LD;
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (stat.lo_lt_hi)
                begin
                    ctrl.op    = OP_SRCH_RD;
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    ctrl.op    = OP_SHIFT_INIT;
                    state_next = S_SHIFT;
                end
            end
            S_SRCH_CMP:
            begin
                ctrl.op    = OP_SRCH_CMP;
                state_next = S_SRCH;
            end
            S_SHIFT:
            begin
                if (stat.o_gt_lo)
                begin
                    ctrl.op    = OP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    ctrl.op    = OP_INSERT;
                    state_next = S_SORT_I;
                end
            end
            S_SHIFT_WR:
            begin
                ctrl.op    = OP_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_EMIT_START:
            begin
                if (stat.out_free)
                begin
                    if (stat.count_zero)
                    begin
                        ctrl.op    = OP_EMIT_EMPTY;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctrl.op    = OP_EMIT_FIRST;
                        state_next = S_EMIT_OUT;
                    end
                end
            end
            S_EMIT_RD:
            begin
                ctrl.op    = OP_EMIT_RD;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = OP_EMIT_OUT;
                    state_next = stat.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/zodl_dp.sv
module zodl_dp
    import zodl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  zodl_ctrl_t        ctrl,
    output zodl_stat_t        stat,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [TAG_W-1:0]  in_tag,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [SLOT_W-1:0] in_slot,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CODE_W-1:0] out_code,
    output logic [TAG_W-1:0]  out_tag,
    output logic [KEY_W-1:0]  out_key,
    output logic [SLOT_W-1:0] out_slot,
    output logic              out_last
);

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dirty_reg, dirty_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic [ADDR_W-1:0] o_reg, o_next;
    logic [ADDR_W-1:0] e_reg, e_next;
    logic [TAG_W-1:0]  cur_tag_reg, cur_tag_next;
    logic [KEY_W-1:0]  cur_key_reg, cur_key_next;

    logic              valid_reg, valid_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [TAG_W-1:0]  otag_reg, otag_next;
    logic [KEY_W-1:0]  okey_reg, okey_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic              olast_reg, olast_next;

    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [ENT_W-1:0]  wdata, rdata;
    logic [TAG_W-1:0]  rd_tag;
    logic [KEY_W-1:0]  rd_key;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W:0]    mid_sum;

    zodl_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_tag   = rdata[ENT_W-1:KEY_W];
    assign rd_key   = rdata[KEY_W-1:0];
    assign count_m1 = count_reg - CNT_W'(1);
    assign mid_sum  = (CNT_W+1)'(lo_reg) + (CNT_W+1)'(hi_reg);

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.slot_none  = (slot_reg == SLOT_NONE);
        stat.full       = (count_reg == CNT_W'(DEPTH));
        stat.rm_bad     = (slot_reg >= SLOT_W'(count_reg));
        stat.rm_last    = (slot_reg == SLOT_W'(count_m1));
        stat.dirty      = dirty_reg;
        stat.i_done     = (i_reg >= count_reg);
        stat.lo_lt_hi   = (lo_reg < hi_reg);
        stat.o_gt_lo    = (CNT_W'(o_reg) > lo_reg);
        stat.count_zero = (count_reg == '0);
        stat.emit_last  = ((CNT_W'(e_reg) + CNT_W'(1)) == count_reg);
        stat.out_free   = !valid_reg || out_ready;
    end

    always_comb
    begin
        cmd_next     = cmd_reg;
        tag_next     = tag_reg;
        key_next     = key_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        dirty_next   = dirty_reg;
        i_next       = i_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        o_next       = o_reg;
        e_next       = e_reg;
        cur_tag_next = cur_tag_reg;
        cur_key_next = cur_key_reg;
        valid_next   = valid_reg && !out_ready;
        code_next    = code_reg;
        otag_next    = otag_reg;
        okey_next    = okey_reg;
        oslot_next   = oslot_reg;
        olast_next   = olast_reg;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = '0;
        raddr        = '0;
        wdata        = {cur_tag_reg, cur_key_reg};

        unique case (ctrl.op)
            OP_LATCH:
            begin
                cmd_next  = in_cmd;
                tag_next  = in_tag;
                key_next  = in_key;
                slot_next = in_slot;
            end
            OP_REG_IGN, OP_FULL, OP_RM_IGN, OP_RM_LAST, OP_EMIT_EMPTY:
            begin
                valid_next = 1'b1;
                otag_next  = '0;
                okey_next  = '0;
                oslot_next = '0;
                olast_next = 1'b1;
                unique case (ctrl.op)
                    OP_REG_IGN: code_next = RC_REG_IGN;
                    OP_FULL:    code_next = RC_FULL;
                    OP_RM_IGN:  code_next = RC_RM_IGN;
                    OP_RM_LAST: code_next = RC_RM_LAST;
                    default:    code_next = RC_EMPTY;
                endcase
                if (ctrl.op == OP_RM_LAST)
                begin
                    count_next = count_m1;
                end
            end
            OP_REG:
            begin
                we         = 1'b1;
                waddr      = count_reg[ADDR_W-1:0];
                wdata      = {tag_reg, key_reg};
                count_next = count_reg + CNT_W'(1);
                dirty_next = 1'b1;
                valid_next = 1'b1;
                code_next  = RC_REGISTERED;
                otag_next  = tag_reg;
                okey_next  = '0;
                oslot_next = SLOT_W'(count_reg);
                olast_next = 1'b1;
            end
            OP_MOVE_RD:
            begin
                re    = 1'b1;
                raddr = count_m1[ADDR_W-1:0];
            end
            OP_MOVE_WR:
            begin
                we         = 1'b1;
                waddr      = slot_reg[ADDR_W-1:0];
                wdata      = rdata;
                count_next = count_m1;
                dirty_next = 1'b1;
                valid_next = 1'b1;
                code_next  = RC_MOVED;
                otag_next  = rd_tag;
                okey_next  = '0;
                oslot_next = slot_reg;
                olast_next = 1'b1;
            end
            OP_SORT_BEGIN:
            begin
                i_next     = CNT_W'(1);
                dirty_next = 1'b0;
            end
            OP_SORT_RD:
            begin
                re      = 1'b1;
                raddr   = i_reg[ADDR_W-1:0];
                lo_next = '0;
                hi_next = i_reg;
            end
            OP_SORT_LD:
            begin
                cur_tag_next = rd_tag;
                cur_key_next = rd_key;
            end
            OP_SRCH_RD:
            begin
                re       = 1'b1;
                raddr    = mid_sum[ADDR_W:1];
                mid_next = mid_sum[ADDR_W:1];
            end
            OP_SRCH_CMP:
            begin
                if ($signed(cur_key_reg) < $signed(rd_key))
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                else
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
            end
            OP_SHIFT_INIT:
            begin
                o_next = i_reg[ADDR_W-1:0];
            end
            OP_SHIFT_RD:
            begin
                re    = 1'b1;
                raddr = o_reg - ADDR_W'(1);
            end
            OP_SHIFT_WR:
            begin
                we     = 1'b1;
                waddr  = o_reg;
                wdata  = rdata;
                o_next = o_reg - ADDR_W'(1);
            end
            OP_INSERT:
            begin
                we     = 1'b1;
                waddr  = lo_reg[ADDR_W-1:0];
                i_next = i_reg + CNT_W'(1);
            end
            OP_EMIT_FIRST:
            begin
                re     = 1'b1;
                raddr  = '0;
                e_next = '0;
            end
            OP_EMIT_RD:
            begin
                re    = 1'b1;
                raddr = e_reg;
            end
            OP_EMIT_OUT:
            begin
                valid_next = 1'b1;
                code_next  = RC_ENTRY;
                otag_next  = rd_tag;
                okey_next  = rd_key;
                oslot_next = SLOT_W'(e_reg);
                olast_next = stat.emit_last;
                e_next     = e_reg + ADDR_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dirty_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            dirty_reg <= dirty_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        tag_reg     <= tag_next;
        key_reg     <= key_next;
        slot_reg    <= slot_next;
        i_reg       <= i_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        o_reg       <= o_next;
        e_reg       <= e_next;
        cur_tag_reg <= cur_tag_next;
        cur_key_reg <= cur_key_next;
        code_reg    <= code_next;
        otag_reg    <= otag_next;
        okey_reg    <= okey_next;
        oslot_reg   <= oslot_next;
        olast_reg   <= olast_next;
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;
    assign out_tag   = otag_reg;
    assign out_key   = okey_reg;
    assign out_slot  = oslot_reg;
    assign out_last  = olast_reg;

endmodule

// File: src/z_ordered_display_list.sv
// Depth-ordered display list of up to DEPTH (tag, signed key) entries held in one
// single-port-read RAM. One transaction is taken at a time: register and unregister
// finish in decode (a move adds a write state), plus any wait on m_tready. Render
// sorts first when the order has changed since the last sort: a binary insertion
// sort with, per entry i, one RAM read per search probe (about log2(i)) and one per
// entry shifted, all bound by the one RAM read port. It then emits every entry in
// slot order, last flag on the final one; an empty list gives a single empty result.
module z_ordered_display_list
    import zodl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // tag[15:0], depth_key[47:16], slot[54:48], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_tag[15:0], out_key[47:16], out_slot[54:48], pad
    output logic [2:0]  m_tuser,   // code[2:0]
    output logic        m_tlast
);

    zodl_ctrl_t        ctrl;
    zodl_stat_t        stat;
    logic              idle;
    logic              in_fire;
    logic [CODE_W-1:0] code;
    logic [TAG_W-1:0]  out_tag;
    logic [KEY_W-1:0]  out_key;
    logic [SLOT_W-1:0] out_slot;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    zodl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_fire(in_fire),
        .stat   (stat),
        .ctrl   (ctrl),
        .idle   (idle)
    );

    zodl_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .in_cmd   (s_tuser),
        .in_tag   (s_tdata[15:0]),
        .in_key   (s_tdata[47:16]),
        .in_slot  (s_tdata[54:48]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_code (code),
        .out_tag  (out_tag),
        .out_key  (out_key),
        .out_slot (out_slot),
        .out_last (m_tlast)
    );

    assign m_tuser = code;
    assign m_tdata = {1'b0, out_slot, out_key, out_tag};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != RC_ENTRY) |-> m_tlast)
        else $error("single result without last flag");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == RC_EMPTY) |-> (m_tdata == '0))
        else $error("empty result carries data");

endmodule
